// ===== hw/rtl/abf_pkg.sv =====
package abf_pkg;

   localparam int MAX_RESULTS = 4;
   localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);

   // register indexes
   localparam logic [1:0] CSR_PARITY_LIMIT = 2'd0;
   localparam logic [1:0] CSR_MAX_LENGTH   = 2'd1;
   localparam logic [1:0] CSR_DLE_MIN      = 2'd2;

   localparam logic [2:0] PARITY_LIMIT_RESET = 3'd4;
   localparam logic [7:0] MAX_LENGTH_RESET   = 8'd240;
   localparam logic [7:0] DLE_MIN_RESET      = 8'd20;
   localparam logic [7:0] TEXT_CAP           = 8'd250;

   localparam logic [7:0] BYTE_SYN = 8'h16;
   localparam logic [7:0] BYTE_SOH = 8'h01;
   localparam logic [7:0] BYTE_ETX = 8'h83;
   localparam logic [7:0] BYTE_ETB = 8'h97;
   localparam logic [7:0] BYTE_DLE = 8'h7f;

   localparam logic [1:0] KIND_TEXT  = 2'd0;
   localparam logic [1:0] KIND_STATE = 2'd1;
   localparam logic [1:0] KIND_FRAME = 2'd2;

   localparam logic [2:0] ST_HUNT  = 3'd0;
   localparam logic [2:0] ST_SYNC2 = 3'd1;
   localparam logic [2:0] ST_SOH   = 3'd2;
   localparam logic [2:0] ST_TEXT  = 3'd3;
   localparam logic [2:0] ST_CRC1  = 3'd4;
   localparam logic [2:0] ST_CRC2  = 3'd5;
   localparam logic [2:0] ST_END   = 3'd6;

   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] frame_state;
      logic [7:0] data_byte;
      logic [7:0] byte_index;
      logic [7:0] text_length;
      logic [7:0] crc_first;
      logic [7:0] crc_second;
   } abf_result_type;

   // all result words caused by one input bit
   typedef struct packed {
      logic [COUNT_W-1:0]                   count;
      abf_result_type [MAX_RESULTS-1:0]     res;
   } abf_group_type;

   function automatic abf_result_type make_result(
      input logic [1:0] kind,
      input logic [2:0] st,
      input logic [7:0] data,
      input logic [7:0] idx,
      input logic [7:0] len,
      input logic [7:0] c0,
      input logic [7:0] c1
   );
      abf_result_type r;
      r.kind        = kind;
      r.frame_state = st;
      r.data_byte   = data;
      r.byte_index  = idx;
      r.text_length = len;
      r.crc_first   = c0;
      r.crc_second  = c1;
      return r;
   endfunction

endpackage

// ===== hw/rtl/abf_core.sv =====
module abf_core
   import abf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic          req_bit_in,
   input  logic          csr_wr_en,
   input  logic [1:0]    csr_index,
   input  logic [7:0]    csr_wr_data,
   input  logic          grp_ready,
   output logic          grp_push,
   output abf_group_type grp_data
);

   typedef enum logic [2:0] {
      PH_HUNT  = ST_HUNT,
      PH_SYNC2 = ST_SYNC2,
      PH_SOH   = ST_SOH,
      PH_TEXT  = ST_TEXT,
      PH_CRC1  = ST_CRC1,
      PH_CRC2  = ST_CRC2,
      PH_END   = ST_END
   } phase_type;

   logic       in_valid_ff, in_valid_in;
   logic       in_bit_ff;
   logic [2:0] par_limit_ff;
   logic [7:0] max_len_ff;
   logic [7:0] dle_min_ff;

   phase_type  phase_ff, phase_in;
   logic [7:0] shift_ff, shift_in;
   logic [3:0] bitcnt_ff, bitcnt_in;
   logic [7:0] len_ff, len_in;
   logic [2:0] pfc_ff, pfc_in;
   logic [7:0] crc0_ff, crc0_in;
   logic [7:0] crc1_ff, crc1_in;
   logic [7:0] recent_ff [3];
   logic [7:0] recent_in [3];

   logic       consume;
   logic       req_accept;
   logic [7:0] ch;
   logic [3:0] bitcnt_nx;
   logic [7:0] len1, len2, lim;
   logic       even_par;
   logic [2:0] pfc1;
   logic       parity_abort;
   logic       clr_frame, clr_byte;
   logic       goto_end;
   abf_result_type text_res, zero_rep;

   assign consume    = in_valid_ff & grp_ready;
   assign req_stall  = in_valid_ff & ~grp_ready;
   assign req_accept = req_valid & ~req_stall;
   assign in_valid_in = req_accept | (in_valid_ff & ~consume);

   // LSB first: new bit enters at the top
   assign ch        = {in_bit_ff, shift_ff[7:1]};
   assign bitcnt_nx = bitcnt_ff + 4'd1;
   assign len1      = len_ff + 8'd1;
   assign len2      = (len1 >= 8'd3) ? len1 - 8'd3 : 8'd0;
   assign lim       = (max_len_ff > TEXT_CAP) ? TEXT_CAP : max_len_ff;
   assign even_par  = ~^ch;
   assign pfc1      = (even_par && pfc_ff != 3'd7) ? pfc_ff + 3'd1 : pfc_ff;
   assign parity_abort = even_par && (pfc1 > par_limit_ff);

   assign text_res = make_result(KIND_TEXT, ST_TEXT, ch, len_ff, len1, crc0_ff, crc1_ff);
   assign zero_rep = make_result(KIND_STATE, ST_HUNT, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);

   always_comb begin
      phase_in  = phase_ff;
      shift_in  = shift_ff;
      bitcnt_in = bitcnt_ff;
      len_in    = len_ff;
      pfc_in    = pfc_ff;
      crc0_in   = crc0_ff;
      crc1_in   = crc1_ff;
      recent_in = recent_ff;
      clr_frame = 1'b0;
      clr_byte  = 1'b0;
      goto_end  = 1'b0;
      grp_data  = '0;

      if (consume) begin
         shift_in  = ch;
         bitcnt_in = bitcnt_nx;
         if (bitcnt_nx[3]) begin
            unique case (phase_ff)
               PH_HUNT: begin
                  if (ch == BYTE_SYN) begin
                     phase_in = PH_SYNC2;
                     clr_byte = 1'b1;
                     grp_data.count  = COUNT_W'(1);
                     grp_data.res[0] = make_result(KIND_STATE, ST_SYNC2, 8'd0, 8'd0,
                                                   len_ff, crc0_ff, crc1_ff);
                  end else begin
                     // slide the window by one bit
                     bitcnt_in = 4'd7;
                  end
               end
               PH_SYNC2: begin
                  grp_data.count = COUNT_W'(1);
                  if (ch == BYTE_SYN) begin
                     phase_in = PH_SOH;
                     clr_byte = 1'b1;
                     grp_data.res[0] = make_result(KIND_STATE, ST_SOH, 8'd0, 8'd0,
                                                   len_ff, crc0_ff, crc1_ff);
                  end else begin
                     clr_frame = 1'b1;
                     grp_data.res[0] = zero_rep;
                  end
               end
               PH_SOH: begin
                  clr_frame = 1'b1;
                  grp_data.count  = COUNT_W'(1);
                  grp_data.res[0] = zero_rep;
                  if (ch == BYTE_SOH) begin
                     grp_data.res[0].frame_state = ST_TEXT;
                  end
               end
               PH_TEXT: begin
                  len_in       = len1;
                  pfc_in       = pfc1;
                  recent_in[0] = ch;
                  recent_in[1] = recent_ff[0];
                  recent_in[2] = recent_ff[1];
                  grp_data.res[0] = text_res;
                  grp_data.count  = COUNT_W'(2);
                  if (parity_abort) begin
                     clr_frame = 1'b1;
                     grp_data.res[1] = zero_rep;
                  end else if (ch == BYTE_ETX || ch == BYTE_ETB) begin
                     phase_in = PH_CRC1;
                     clr_byte = 1'b1;
                     grp_data.res[1] = make_result(KIND_STATE, ST_CRC1, 8'd0, 8'd0,
                                                   len1, crc0_ff, crc1_ff);
                  end else if (len1 > lim) begin
                     clr_frame = 1'b1;
                     grp_data.res[1] = zero_rep;
                  end else if (len1 > dle_min_ff && ch == BYTE_DLE) begin
                     // CRC is the two bytes before the DLE
                     clr_frame = 1'b1;
                     goto_end  = 1'b1;
                     grp_data.count  = COUNT_W'(4);
                     grp_data.res[1] = make_result(KIND_STATE, ST_CRC2, 8'd0, 8'd0,
                                                   len2, recent_ff[1], recent_ff[0]);
                     grp_data.res[2] = make_result(KIND_FRAME, ST_CRC2, 8'd0, 8'd0,
                                                   len2, recent_ff[1], recent_ff[0]);
                     grp_data.res[3] = zero_rep;
                     grp_data.res[3].frame_state = ST_END;
                  end else begin
                     clr_byte = 1'b1;
                     grp_data.count = COUNT_W'(1);
                  end
               end
               PH_CRC1: begin
                  crc0_in  = ch;
                  phase_in = PH_CRC2;
                  clr_byte = 1'b1;
                  grp_data.count  = COUNT_W'(1);
                  grp_data.res[0] = make_result(KIND_STATE, ST_CRC2, 8'd0, 8'd0,
                                                len_ff, ch, crc1_ff);
               end
               PH_CRC2: begin
                  clr_frame = 1'b1;
                  goto_end  = 1'b1;
                  grp_data.count  = COUNT_W'(2);
                  grp_data.res[0] = make_result(KIND_FRAME, ST_CRC2, 8'd0, 8'd0,
                                                len_ff, crc0_ff, ch);
                  grp_data.res[1] = zero_rep;
                  grp_data.res[1].frame_state = ST_END;
               end
               default: begin
                  clr_frame = 1'b1;
                  grp_data.count  = COUNT_W'(1);
                  grp_data.res[0] = zero_rep;
               end
            endcase
         end

         if (clr_byte || clr_frame) begin
            shift_in  = 8'd0;
            bitcnt_in = 4'd0;
         end
         if (clr_frame) begin
            len_in    = 8'd0;
            pfc_in    = 3'd0;
            crc0_in   = 8'd0;
            crc1_in   = 8'd0;
            recent_in = '{default: 8'd0};
            // frame end idles one byte, SOH after the sync pair enters text, every other restart goes to hunt
            if (goto_end) begin
               phase_in = PH_END;
            end else if (phase_ff == PH_SOH && ch == BYTE_SOH) begin
               phase_in = PH_TEXT;
            end else begin
               phase_in = PH_HUNT;
            end
         end
      end
   end

   assign grp_push = consume && (grp_data.count != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         par_limit_ff <= PARITY_LIMIT_RESET;
         max_len_ff   <= MAX_LENGTH_RESET;
         dle_min_ff   <= DLE_MIN_RESET;
         phase_ff     <= PH_HUNT;
         shift_ff     <= 8'd0;
         bitcnt_ff    <= 4'd0;
         len_ff       <= 8'd0;
         pfc_ff       <= 3'd0;
         crc0_ff      <= 8'd0;
         crc1_ff      <= 8'd0;
         recent_ff    <= '{default: 8'd0};
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_PARITY_LIMIT: par_limit_ff <= csr_wr_data[2:0];
               CSR_MAX_LENGTH:   max_len_ff   <= csr_wr_data;
               CSR_DLE_MIN:      dle_min_ff   <= csr_wr_data;
               default: ;
            endcase
         end
         phase_ff  <= phase_in;
         shift_ff  <= shift_in;
         bitcnt_ff <= bitcnt_in;
         len_ff    <= len_in;
         pfc_ff    <= pfc_in;
         crc0_ff   <= crc0_in;
         crc1_ff   <= crc1_in;
         recent_ff <= recent_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_bit_ff <= req_bit_in;
      end
   end

endmodule

// ===== hw/rtl/abf_rsp_queue.sv =====
module abf_rsp_queue
   import abf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          grp_push,
   input  abf_group_type grp_data,
   output logic          grp_ready,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [1:0]    rsp_kind,
   output logic [2:0]    rsp_frame_state,
   output logic [7:0]    rsp_data_byte,
   output logic [7:0]    rsp_byte_index,
   output logic [7:0]    rsp_text_length,
   output logic [7:0]    rsp_crc_first,
   output logic [7:0]    rsp_crc_second,
   output logic          rsp_last
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SEL_W = $clog2(MAX_RESULTS);

   abf_group_type      grp_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SEL_W-1:0]   sel_ff;

   abf_group_type      head;
   abf_result_type     cur;
   logic               is_last;
   logic               rsp_take;
   logic               pop;

   assign head      = grp_ff[rd_ptr_ff];
   assign cur       = head.res[sel_ff];
   assign grp_ready = (cnt_ff != CNT_W'(DEPTH));
   assign rsp_valid = (cnt_ff != '0);
   assign is_last   = (COUNT_W'(sel_ff) == head.count - COUNT_W'(1));
   assign rsp_take  = rsp_valid & ~rsp_stall;
   assign pop       = rsp_take & is_last;

   assign rsp_kind        = cur.kind;
   assign rsp_frame_state = cur.frame_state;
   assign rsp_data_byte   = cur.data_byte;
   assign rsp_byte_index  = cur.byte_index;
   assign rsp_text_length = cur.text_length;
   assign rsp_crc_first   = cur.crc_first;
   assign rsp_crc_second  = cur.crc_second;
   assign rsp_last        = is_last;

   always_comb begin
      cnt_in = cnt_ff;
      if (grp_push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (!grp_push && pop) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
         sel_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (grp_push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
            sel_ff    <= '0;
         end else if (rsp_take) begin
            sel_ff <= sel_ff + SEL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (grp_push) begin
         grp_ff[wr_ptr_ff] <= grp_data;
      end
   end

endmodule

// ===== hw/rtl/acars_bit_framer.sv =====
// Flow: a bit accepted into the input register is framed into the group queue, whose
// result words are offered on the result port. Throughput: one bit per cycle unless
// a full queue stalls it; a byte boundary yields up to 4 words, drained one per
// cycle unless rsp_stall, from a 2-deep group queue, set by the single result port.
// Reset (synchronous, active high): hunting for SYN, counters, CRC and queue cleared,
// registers back to parity limit 4, max length 240, DLE minimum 20.
module acars_bit_framer
   import abf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_bit_in,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wr_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [2:0] rsp_frame_state,
   output logic [7:0] rsp_data_byte,
   output logic [7:0] rsp_byte_index,
   output logic [7:0] rsp_text_length,
   output logic [7:0] rsp_crc_first,
   output logic [7:0] rsp_crc_second,
   output logic       rsp_last
);

   logic          grp_ready;
   logic          grp_push;
   abf_group_type grp_data;

   abf_core u_core (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_bit_in  (req_bit_in),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .grp_ready   (grp_ready),
      .grp_push    (grp_push),
      .grp_data    (grp_data)
   );

   abf_rsp_queue u_rsp_queue (
      .clock           (clock),
      .reset           (reset),
      .grp_push        (grp_push),
      .grp_data        (grp_data),
      .grp_ready       (grp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_frame_state (rsp_frame_state),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_byte_index  (rsp_byte_index),
      .rsp_text_length (rsp_text_length),
      .rsp_crc_first   (rsp_crc_first),
      .rsp_crc_second  (rsp_crc_second),
      .rsp_last        (rsp_last)
   );

`ifndef NO_ASSERTIONS
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      grp_push |-> grp_ready)
      else $error("group pushed into full queue");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      grp_push |-> (grp_data.count != '0 && grp_data.count <= COUNT_W'(MAX_RESULTS)))
      else $error("bad group word count");

   a_text_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_TEXT) |-> rsp_frame_state == ST_TEXT)
      else $error("text word outside text state");

   a_frame_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_FRAME) |-> (rsp_frame_state == ST_CRC2 && !rsp_last))
      else $error("frame complete word malformed");
`endif

endmodule

// ===== sim/acars_bit_framer_checker.sv =====
`timescale 1ns / 1ps
module acars_bit_framer_checker
   import abf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic       req_bit_in,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wr_data,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [1:0] rsp_kind,
   input  logic [2:0] rsp_frame_state,
   input  logic [7:0] rsp_data_byte,
   input  logic [7:0] rsp_byte_index,
   input  logic [7:0] rsp_text_length,
   input  logic [7:0] rsp_crc_first,
   input  logic [7:0] rsp_crc_second,
   input  logic       rsp_last,
   output int         fail_count,
   output int         pending_words,
   output int         words_checked,
   output int         frames_seen
);

   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] frame_state;
      logic [7:0] data_byte;
      logic [7:0] byte_index;
      logic [7:0] text_length;
      logic [7:0] crc_first;
      logic [7:0] crc_second;
      logic       last;
   } framer_word_type;

   // register copies
   logic [2:0] cfg_parity_limit;
   logic [7:0] cfg_max_length;
   logic [7:0] cfg_dle_min;

   // framer state
   logic [2:0] phase;
   logic [7:0] shifter;
   logic [3:0] bits_in_byte;
   logic [7:0] msg_len;
   logic [2:0] parity_fails;
   logic [7:0] crc_byte [2];
   logic [7:0] recent [3];

   framer_word_type words_due [$];
   framer_word_type step_words [$];
   int fails = 0;
   int checked = 0;
   int frames = 0;

   task automatic add_word(input logic [1:0] k, input logic [2:0] st,
                           input logic [7:0] d, input logic [7:0] idx);
      framer_word_type w;
      w.kind        = k;
      w.frame_state = st;
      w.data_byte   = d;
      w.byte_index  = idx;
      w.text_length = msg_len;
      w.crc_first   = crc_byte[0];
      w.crc_second  = crc_byte[1];
      w.last        = 1'b0;
      step_words.push_back(w);
   endtask

   task automatic report_phase();
      add_word(KIND_STATE, phase, 8'd0, 8'd0);
   endtask

   task automatic clear_byte();
      shifter      = '0;
      bits_in_byte = '0;
   endtask

   task automatic restart_frame();
      clear_byte();
      phase        = ST_HUNT;
      msg_len      = '0;
      parity_fails = '0;
      crc_byte[0]  = '0;
      crc_byte[1]  = '0;
      recent[0]    = '0;
      recent[1]    = '0;
      recent[2]    = '0;
   endtask

   task automatic close_frame();
      add_word(KIND_FRAME, ST_CRC2, 8'd0, 8'd0);
      restart_frame();
      phase = ST_END;
      report_phase();
   endtask

   task automatic take_text_byte(input logic [7:0] ch);
      logic [7:0] cap;
      logic [7:0] idx;
      cap = (cfg_max_length > TEXT_CAP) ? TEXT_CAP : cfg_max_length;
      idx = msg_len;
      msg_len   = msg_len + 8'd1;
      recent[2] = recent[1];
      recent[1] = recent[0];
      recent[0] = ch;
      add_word(KIND_TEXT, ST_TEXT, ch, idx);
      if (!(^ch)) begin
         if (parity_fails < 3'd7) parity_fails = parity_fails + 3'd1;
         if (parity_fails > cfg_parity_limit) begin
            restart_frame();
            report_phase();
            return;
         end
      end
      if (ch == BYTE_ETX || ch == BYTE_ETB) begin
         phase = ST_CRC1;
         clear_byte();
         report_phase();
         return;
      end
      if (msg_len > cap) begin
         restart_frame();
         report_phase();
         return;
      end
      if (msg_len > cfg_dle_min && ch == BYTE_DLE) begin
         // CRC sits in the two bytes before the DLE
         msg_len     = (msg_len >= 8'd3) ? msg_len - 8'd3 : 8'd0;
         crc_byte[0] = recent[2];
         crc_byte[1] = recent[1];
         phase       = ST_CRC2;
         report_phase();
         close_frame();
         return;
      end
      clear_byte();
   endtask

   task automatic frame_bit(input logic b);
      logic [7:0] cur;
      shifter      = {b, shifter[7:1]};
      bits_in_byte = bits_in_byte + 4'd1;
      if (bits_in_byte < 4'd8) return;
      cur = shifter;
      case (phase)
         ST_HUNT: begin
            if (cur == BYTE_SYN) begin
               phase = ST_SYNC2;
               clear_byte();
               report_phase();
            end else begin
               // slide the window by one bit
               bits_in_byte = 4'd7;
            end
         end
         ST_SYNC2: begin
            if (cur == BYTE_SYN) begin
               phase = ST_SOH;
               clear_byte();
            end else begin
               restart_frame();
            end
            report_phase();
         end
         ST_SOH: begin
            restart_frame();
            if (cur == BYTE_SOH) phase = ST_TEXT;
            report_phase();
         end
         ST_TEXT: take_text_byte(cur);
         ST_CRC1: begin
            crc_byte[0] = cur;
            phase = ST_CRC2;
            clear_byte();
            report_phase();
         end
         ST_CRC2: begin
            crc_byte[1] = cur;
            close_frame();
         end
         default: begin
            restart_frame();
            report_phase();
         end
      endcase
   endtask

   function automatic int field_diff(input string name, input logic [7:0] want,
                                     input logic [7:0] got);
      if (want === got) return 0;
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin
      framer_word_type got;
      framer_word_type want;
      int bad;
      if (reset) begin
         cfg_parity_limit = PARITY_LIMIT_RESET;
         cfg_max_length   = MAX_LENGTH_RESET;
         cfg_dle_min      = DLE_MIN_RESET;
         restart_frame();
         words_due.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_PARITY_LIMIT: cfg_parity_limit = csr_wr_data[2:0];
               CSR_MAX_LENGTH:   cfg_max_length   = csr_wr_data;
               CSR_DLE_MIN:      cfg_dle_min      = csr_wr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            step_words.delete();
            frame_bit(req_bit_in);
            if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
            foreach (step_words[i]) words_due.push_back(step_words[i]);
         end
         if (rsp_valid && !rsp_stall) begin
            got.kind        = rsp_kind;
            got.frame_state = rsp_frame_state;
            got.data_byte   = rsp_data_byte;
            got.byte_index  = rsp_byte_index;
            got.text_length = rsp_text_length;
            got.crc_first   = rsp_crc_first;
            got.crc_second  = rsp_crc_second;
            got.last        = rsp_last;
            if (words_due.size() == 0) begin
               $error("result word with nothing pending: kind %0d state %0d data %0d",
                      got.kind, got.frame_state, got.data_byte);
               fails++;
            end else begin
               want = words_due.pop_front();
               bad = field_diff("kind", want.kind, got.kind)
                   + field_diff("frame_state", want.frame_state, got.frame_state)
                   + field_diff("data_byte", want.data_byte, got.data_byte)
                   + field_diff("byte_index", want.byte_index, got.byte_index)
                   + field_diff("text_length", want.text_length, got.text_length)
                   + field_diff("crc_first", want.crc_first, got.crc_first)
                   + field_diff("crc_second", want.crc_second, got.crc_second)
                   + field_diff("last", want.last, got.last);
               fails += bad;
               checked++;
               if (want.kind == KIND_FRAME) frames++;
            end
         end
      end
      fail_count    <= fails;
      pending_words <= words_due.size();
      words_checked <= checked;
      frames_seen   <= frames;
   end

endmodule

// ===== sim/acars_bit_framer_tb.sv =====
`timescale 1ns / 1ps
module acars_bit_framer_tb
   import abf_pkg::*;
();

   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_BITS  = 24;

   typedef enum int {END_ETX, END_ETB, END_DLE, END_OPEN} frame_end_type;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   logic       req_bit_in  = 1'b0;
   logic       csr_wr_en   = 1'b0;
   logic [1:0] csr_index   = CSR_PARITY_LIMIT;
   logic [7:0] csr_wr_data = '0;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   logic [1:0] rsp_kind;
   logic [2:0] rsp_frame_state;
   logic [7:0] rsp_data_byte;
   logic [7:0] rsp_byte_index;
   logic [7:0] rsp_text_length;
   logic [7:0] rsp_crc_first;
   logic [7:0] rsp_crc_second;
   logic       rsp_last;

   int fail_count;
   int pending_words;
   int words_checked;
   int frames_seen;

   int bits_sent      = 0;
   int settings_used  = 0;
   int stall_left     = 0;
   int idle_cycles    = 0;
   bit req_gaps_on    = 1'b0;
   bit rsp_gaps_on    = 1'b0;
   logic [7:0] text_buf [$];

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   acars_bit_framer u_top (.*);

   acars_bit_framer_checker u_checker (.*);

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // result side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (rsp_gaps_on && $urandom_range(0, 3) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= pick_gap();
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("acars_bit_framer_tb: FAIL");
         $finish;
      end
   end

   task automatic send_bit(input logic b);
      int gap;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_bit_in <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bits_sent++;
   endtask

   task automatic send_byte(input logic [7:0] v);
      for (int i = 0; i < 8; i++) send_bit(v[i]);
   endtask

   task automatic send_noise(input int n);
      repeat (n) send_bit(1'($urandom_range(0, 1)));
   endtask

   function automatic logic [7:0] text_char(input bit bad_parity);
      logic [7:0] ch;
      ch = 8'($urandom_range(0, 255));
      if ((^ch) == bad_parity) ch[7] = ~ch[7];
      // keep terminators out; flipping two bits keeps the parity
      if (ch == BYTE_ETX || ch == BYTE_ETB || ch == BYTE_DLE) ch = ch ^ 8'h03;
      return ch;
   endfunction

   task automatic fill_text(input int n, input int bad_pct);
      text_buf.delete();
      repeat (n) text_buf.push_back(text_char($urandom_range(0, 99) < bad_pct));
   endtask

   task automatic send_frame(input frame_end_type ending);
      send_byte(BYTE_SYN);
      send_byte(BYTE_SYN);
      send_byte(BYTE_SOH);
      foreach (text_buf[i]) send_byte(text_buf[i]);
      case (ending) inside
         END_ETX, END_ETB: begin
            send_byte(ending == END_ETX ? BYTE_ETX : BYTE_ETB);
            // two CRC bytes, then the idle byte
            repeat (3) send_byte(8'($urandom_range(0, 255)));
         end
         END_DLE: begin
            send_byte(BYTE_DLE);
            send_byte(8'($urandom_range(0, 255)));
         end
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(input logic [2:0] plim, input logic [7:0] max_len,
                               input logic [7:0] dle_min);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_PARITY_LIMIT;
      csr_wr_data <= {5'd0, plim};
      @(posedge clock);
      csr_index   <= CSR_MAX_LENGTH;
      csr_wr_data <= max_len;
      @(posedge clock);
      csr_index   <= CSR_DLE_MIN;
      csr_wr_data <= dle_min;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      settings_used++;
   endtask

   task automatic run_sequence();
      int r;
      int len;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         send_noise($urandom_range(1, 20));
      end else if (r < 22) begin
         // broken sync: lone SYN or SYN pair followed by junk
         send_byte(BYTE_SYN);
         if ($urandom_range(0, 1)) send_byte(BYTE_SYN);
         send_byte(8'($urandom_range(0, 255)));
      end else begin
         if ($urandom_range(0, 3) == 0) send_noise($urandom_range(1, 8));
         len = $urandom_range(0, 3);
         fill_text(len, ($urandom_range(0, 2) == 0) ? 15 : 0);
         send_frame(frame_end_type'($urandom_range(0, 3)));
      end
   endtask

   initial begin
      int start_bits;
      logic [2:0] plim;
      logic [7:0] max_len;
      logic [7:0] dle_min;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // misaligned SYN found by the sliding hunt, then a bad second sync
      send_noise(3);
      send_byte(BYTE_SYN);
      send_byte(8'h55);
      // byte extremes; 00 and FF fail parity but stay under the limit
      text_buf = '{8'h00, 8'hFF};
      send_frame(END_ETX);

      wait_drained();
      write_config(3'd0, 8'd21, 8'd3);
      req_gaps_on = 1'b1;
      rsp_gaps_on <= 1'b1;
      // first length past the minimum: DLE closes the frame
      fill_text(3, 0);
      send_frame(END_DLE);
      // single parity failure aborts at limit 0
      text_buf = '{8'h00};
      send_frame(END_OPEN);

      start_bits = bits_sent;
      while (bits_sent < start_bits + RANDOM_BITS) begin
         wait_drained();
         plim    = 3'($urandom_range(0, 7));
         max_len = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(21, 30))
                                               : 8'($urandom_range(21, 250));
         dle_min = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(3, 249))
                                               : 8'($urandom_range(3, 12));
         write_config(plim, max_len, dle_min);
         req_gaps_on = ($urandom_range(0, 3) != 0);
         rsp_gaps_on <= ($urandom_range(0, 3) != 0);
         run_sequence();
      end

      wait_drained();
      $display("Sent %0d bits under %0d register settings; %0d words checked, %0d frames",
               bits_sent, settings_used + 1, words_checked, frames_seen);
      if (fail_count == 0)
         $display("acars_bit_framer_tb: PASS");
      else
         $display("acars_bit_framer_tb: FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/abf_pkg.sv
hw/rtl/abf_core.sv
hw/rtl/abf_rsp_queue.sv
hw/rtl/acars_bit_framer.sv
sim/acars_bit_framer_checker.sv
sim/acars_bit_framer_tb.sv
